@@ design/petri_transition_enable_check_macros.svh @@
// Assertion macros for the transition enable check
`ifndef PETRI_TRANSITION_ENABLE_CHECK_MACROS_SVH
`define PETRI_TRANSITION_ENABLE_CHECK_MACROS_SVH

`ifndef SYNTHESIS
`define PTE_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed");
`define PTE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define PTE_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define PTE_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

@@ design/pte_pkg.sv @@
package pte_pkg;

	localparam int TOKEN_DEPTH    = 64;
	localparam int REQUIRED_DEPTH = 32;

	localparam int TOK_AW  = (TOKEN_DEPTH > 1) ? $clog2(TOKEN_DEPTH) : 1;
	localparam int REQ_AW  = (REQUIRED_DEPTH > 1) ? $clog2(REQUIRED_DEPTH) : 1;
	localparam int TOK_CW  = $clog2(TOKEN_DEPTH + 1);
	localparam int REQ_CW  = $clog2(REQUIRED_DEPTH + 1);
	localparam int SCAN_CW = (TOK_CW > REQ_CW) ? TOK_CW : REQ_CW;

	localparam int PLACE_W = 10;
	localparam int COLOR_W = 8;
	localparam int KEY_W   = PLACE_W + COLOR_W;

	typedef logic [KEY_W-1:0] key_t;

	typedef enum logic [1:0] {
		KIND_TOKEN = 2'd0,
		KIND_REQ   = 2'd1,
		KIND_EVAL  = 2'd2,
		KIND_NONE  = 2'd3
	} kind_t;

endpackage

@@ design/petri_transition_enable_check.sv @@
// channel   signals                      handshake
// -------   --------------------------   -------------------------------
// item in   kind, place, color           start high while busy low
// result    fireable, overflow           done high for one cycle
//
// A load (token or required entry) is written while idle; busy stays low.
// Evaluate with no required entries: result in the cycle after acceptance.
// Evaluate otherwise: busy while each of R required entries is scanned to N, the
// larger of the two fills; each store has one read port, walked once per entry.
// Reset clears the fill counts and the drop flag; store contents need none.
// The receiver cannot stall; done lasts one cycle and a new item may enter then.
`include "petri_transition_enable_check_macros.svh"

module petri_transition_enable_check import pte_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic [1:0]          kind,
	input  logic [PLACE_W-1:0]  place,
	input  logic [COLOR_W-1:0]  color,
	output logic                done,
	output logic                fireable,
	output logic                overflow
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_KEY,
		ST_KEYW,
		ST_SCAN,
		ST_DRAIN,
		ST_CHECK,
		ST_DONE
	} state_t;

	state_t state_q;

	key_t tok_mem [TOKEN_DEPTH];
	key_t req_mem [REQUIRED_DEPTH];
	key_t tok_rd_q;
	key_t req_rd_q;

	logic [TOK_CW-1:0]  tc_q;
	logic [REQ_CW-1:0]  rc_q;
	logic               ovf_q;
	logic [REQ_CW-1:0]  i_q;
	logic [SCAN_CW-1:0] j_q;
	key_t               key_q;
	logic [REQ_CW-1:0]  need_q;
	logic [TOK_CW-1:0]  have_q;
	logic               fail_q;
	logic               vld_s1;
	logic               vreq_s1;
	logic               vtok_s1;
	logic               done_q;
	logic               fire_q;
	logic               ovf_out_q;

	logic               accept;
	kind_t              kind_in;
	key_t               key_in;
	logic               tok_we;
	logic               req_we;
	logic [REQ_AW-1:0]  req_raddr;
	logic [TOK_AW-1:0]  tok_raddr;
	logic [SCAN_CW-1:0] scan_last;

	assign accept  = start && !busy;
	assign kind_in = kind_t'(kind);
	assign key_in  = {place, color};
	assign busy    = (state_q != ST_IDLE);
	assign tok_we  = accept && (kind_in == KIND_TOKEN) && (tc_q != TOK_CW'(TOKEN_DEPTH));
	assign req_we  = accept && (kind_in == KIND_REQ) && (rc_q != REQ_CW'(REQUIRED_DEPTH));

	assign scan_last = ((SCAN_CW'(tc_q) > SCAN_CW'(rc_q)) ? SCAN_CW'(tc_q) : SCAN_CW'(rc_q))
		- SCAN_CW'(1);

	assign req_raddr = (state_q == ST_SCAN) ? j_q[REQ_AW-1:0] : i_q[REQ_AW-1:0];
	assign tok_raddr = j_q[TOK_AW-1:0];

	assign done     = done_q;
	assign fireable = fire_q;
	assign overflow = ovf_out_q;

	always_ff @(posedge clk) begin
		if (tok_we) begin
			tok_mem[tc_q[TOK_AW-1:0]] <= key_in;
		end
		if (req_we) begin
			req_mem[rc_q[REQ_AW-1:0]] <= key_in;
		end
		tok_rd_q <= tok_mem[tok_raddr];
		req_rd_q <= req_mem[req_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			tc_q      <= '0;
			rc_q      <= '0;
			ovf_q     <= 1'b0;
			i_q       <= '0;
			j_q       <= '0;
			key_q     <= '0;
			need_q    <= '0;
			have_q    <= '0;
			fail_q    <= 1'b0;
			vld_s1    <= 1'b0;
			vreq_s1   <= 1'b0;
			vtok_s1   <= 1'b0;
			done_q    <= 1'b0;
			fire_q    <= 1'b0;
			ovf_out_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (vld_s1) begin
				if (vreq_s1 && (req_rd_q == key_q)) begin
					need_q <= need_q + REQ_CW'(1);
				end
				if (vtok_s1 && (tok_rd_q == key_q)) begin
					have_q <= have_q + TOK_CW'(1);
				end
			end
			case (state_q)
				ST_IDLE: begin
					vld_s1 <= 1'b0;
					if (accept) begin
						case (kind_in)
							KIND_TOKEN: begin
								if (tok_we) begin
									tc_q <= tc_q + TOK_CW'(1);
								end else begin
									ovf_q <= 1'b1;
								end
							end
							KIND_REQ: begin
								if (req_we) begin
									rc_q <= rc_q + REQ_CW'(1);
								end else begin
									ovf_q <= 1'b1;
								end
							end
							KIND_EVAL: begin
								if (rc_q == '0) begin
									done_q    <= 1'b1;
									fire_q    <= 1'b0;
									ovf_out_q <= ovf_q;
									tc_q      <= '0;
									ovf_q     <= 1'b0;
								end else begin
									i_q     <= '0;
									fail_q  <= 1'b0;
									state_q <= ST_KEY;
								end
							end
							default: begin
							end
						endcase
					end
				end
				ST_KEY: begin
					state_q <= ST_KEYW;
				end
				ST_KEYW: begin
					key_q   <= req_rd_q;
					j_q     <= '0;
					need_q  <= '0;
					have_q  <= '0;
					state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					vld_s1  <= 1'b1;
					vreq_s1 <= (j_q < SCAN_CW'(rc_q));
					vtok_s1 <= (j_q < SCAN_CW'(tc_q));
					j_q     <= j_q + SCAN_CW'(1);
					if (j_q == scan_last) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					vld_s1  <= 1'b0;
					state_q <= ST_CHECK;
				end
				ST_CHECK: begin
					if (SCAN_CW'(have_q) < SCAN_CW'(need_q)) begin
						fail_q <= 1'b1;
					end
					if (i_q == rc_q - REQ_CW'(1)) begin
						state_q <= ST_DONE;
					end else begin
						i_q     <= i_q + REQ_CW'(1);
						state_q <= ST_KEY;
					end
				end
				ST_DONE: begin
					done_q    <= 1'b1;
					fire_q    <= !fail_q;
					ovf_out_q <= ovf_q;
					tc_q      <= '0;
					rc_q      <= '0;
					ovf_q     <= 1'b0;
					state_q   <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	`PTE_ASSERT_NEXT(a_done_follows, clk, arst_n, state_q == ST_DONE, done_q && state_q == ST_IDLE)
	`PTE_ASSERT_NOW(a_done_cleared, clk, arst_n, done_q, tc_q == '0 && !ovf_q && state_q == ST_IDLE)
	`PTE_ASSERT_NEXT(a_empty_req, clk, arst_n,
		accept && kind_in == KIND_EVAL && rc_q == '0, done_q && !fire_q)
	`PTE_ASSERT_NOW(a_scan_nonempty, clk, arst_n, state_q == ST_SCAN, rc_q != '0)
	`PTE_ASSERT_NOW(a_check_drained, clk, arst_n, state_q == ST_CHECK, !vld_s1)

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 100ps

module testbench;
	import pte_pkg::*;

	typedef struct packed {
		logic fireable;
		logic overflow;
	} verdict_t;

	typedef struct {
		kind_t kind;
		key_t  key;
	} load_t;

	class firing_scoreboard;
		key_t        tokens [TOKEN_DEPTH];
		key_t        needs [REQUIRED_DEPTH];
		int unsigned n_tokens;
		int unsigned n_needs;
		bit          dropped;
		verdict_t    verdicts_due[$];
		int unsigned mismatches;
		int unsigned fired;
		int unsigned flagged;

		function bit transition_enabled();
			int unsigned i;
			int unsigned j;
			int unsigned need;
			int unsigned have;
			if (n_needs == 0) begin
				return 1'b0;
			end
			for (i = 0; i < n_needs; i++) begin
				need = 0;
				have = 0;
				for (j = 0; j < n_needs; j++) begin
					if (needs[j] == needs[i]) begin
						need++;
					end
				end
				for (j = 0; j < n_tokens; j++) begin
					if (tokens[j] == needs[i]) begin
						have++;
					end
				end
				if (have < need) begin
					return 1'b0;
				end
			end
			return 1'b1;
		endfunction

		function void note_item(kind_t kind, key_t key);
			verdict_t v;
			case (kind)
				KIND_TOKEN: begin
					if (n_tokens < TOKEN_DEPTH) begin
						tokens[n_tokens] = key;
						n_tokens++;
					end else begin
						dropped = 1'b1;
					end
				end
				KIND_REQ: begin
					if (n_needs < REQUIRED_DEPTH) begin
						needs[n_needs] = key;
						n_needs++;
					end else begin
						dropped = 1'b1;
					end
				end
				KIND_EVAL: begin
					v.fireable = transition_enabled();
					v.overflow = dropped;
					verdicts_due = {verdicts_due, v};
					n_tokens = 0;
					n_needs = 0;
					dropped = 1'b0;
				end
				default: begin
				end
			endcase
		endfunction

		function void check_result(logic got_fireable, logic got_overflow);
			verdict_t want;
			if (got_fireable === 1'b1) begin
				fired++;
			end
			if (got_overflow === 1'b1) begin
				flagged++;
			end
			if (verdicts_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("result with nothing due: fireable %b overflow %b",
						got_fireable, got_overflow);
				end
				return;
			end
			want = verdicts_due.pop_front();
			if (got_fireable !== want.fireable || got_overflow !== want.overflow) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("mismatch: expected fireable %b overflow %b, got %b %b",
						want.fireable, want.overflow, got_fireable, got_overflow);
				end
			end
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic [1:0]         kind;
	logic [PLACE_W-1:0] place;
	logic [COLOR_W-1:0] color;
	logic               done;
	logic               fireable;
	logic               overflow;

	firing_scoreboard sb;
	bit               burst;
	int unsigned      loads_sent;
	int unsigned      evals_sent;
	int unsigned      ignored_sent;

	petri_transition_enable_check dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.kind(kind),
		.place(place),
		.color(color),
		.done(done),
		.fireable(fireable),
		.overflow(overflow)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#40_000_000;
		$display("testbench NOT OK");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n === 1'b1 && done === 1'b1) begin
			sb.check_result(fireable, overflow);
		end
	end

	function automatic int unsigned pick_gap();
		int unsigned r;
		if (burst) begin
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 55) begin
			return 0;
		end
		if (r < 90) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 40);
	endfunction

	task automatic send(input kind_t k, input key_t key, input int unsigned gap);
		@(negedge clk);
		start <= 1'b1;
		kind  <= k;
		place <= key[KEY_W-1:COLOR_W];
		color <= key[COLOR_W-1:0];
		@(posedge clk);
		while (busy !== 1'b0) begin
			@(posedge clk);
		end
		sb.note_item(k, key);
		case (k)
			KIND_EVAL: evals_sent++;
			KIND_NONE: ignored_sent++;
			default: loads_sent++;
		endcase
		if (gap > 0) begin
			@(negedge clk);
			start <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	task automatic idle_until_drained();
		@(negedge clk);
		start <= 1'b0;
		while (sb.verdicts_due.size() != 0) begin
			@(posedge clk);
		end
	endtask

	task automatic run_transition();
		key_t        pool [4];
		load_t       plan[$];
		load_t       swap;
		load_t       entry;
		int unsigned mode;
		int unsigned n_pool;
		int unsigned n_req;
		int unsigned n_extra;
		int unsigned skip;
		int unsigned i;
		int unsigned j;
		mode = $urandom_range(0, 99);
		burst = ($urandom_range(0, 4) == 0);
		n_pool = $urandom_range(1, 4);
		pool[0] = key_t'($urandom);
		for (i = 1; i < n_pool; i++) begin
			if ($urandom_range(0, 1) == 1) begin
				pool[i] = pool[0] ^ (key_t'(1) << $urandom_range(0, KEY_W - 1));
			end else begin
				pool[i] = key_t'($urandom);
			end
		end
		if (mode < 10) begin
			n_extra = $urandom_range(3, 12);
			for (i = 0; i < n_extra; i++) begin
				send(kind_t'($urandom_range(0, 3)), key_t'($urandom), pick_gap());
			end
			return;
		end
		if (mode < 16) begin
			n_req = $urandom_range(REQUIRED_DEPTH - 2, REQUIRED_DEPTH + 3);
		end else begin
			n_req = $urandom_range(0, 6);
		end
		for (i = 0; i < n_req; i++) begin
			entry.kind = KIND_REQ;
			entry.key = pool[$urandom_range(0, n_pool - 1)];
			plan = {plan, entry};
		end
		if ($urandom_range(0, 2) != 0) begin
			skip = ($urandom_range(0, 1) == 1) ? $urandom_range(0, n_req) : n_req;
			for (i = 0; i < n_req; i++) begin
				if (i != skip) begin
					entry.kind = KIND_TOKEN;
					entry.key = plan[i].key;
					plan = {plan, entry};
				end
			end
		end
		if (mode < 22 && mode >= 16) begin
			n_extra = TOKEN_DEPTH + $urandom_range(1, 4) - (plan.size() - n_req);
		end else begin
			n_extra = $urandom_range(0, 4);
		end
		for (i = 0; i < n_extra; i++) begin
			entry.kind = KIND_TOKEN;
			if ($urandom_range(0, 4) == 0) begin
				entry.key = key_t'($urandom);
			end else begin
				entry.key = pool[$urandom_range(0, n_pool - 1)];
			end
			plan = {plan, entry};
		end
		for (i = plan.size(); i > 1; i--) begin
			j = $urandom_range(0, i - 1);
			swap = plan[i - 1];
			plan[i - 1] = plan[j];
			plan[j] = swap;
		end
		for (i = 0; i < plan.size(); i++) begin
			if ($urandom_range(0, 19) == 0) begin
				send(KIND_NONE, key_t'($urandom), pick_gap());
			end
			send(plan[i].kind, plan[i].key, pick_gap());
		end
		send(KIND_EVAL, key_t'($urandom), pick_gap());
		if ($urandom_range(0, 9) == 0) begin
			idle_until_drained();
		end
	endtask

	initial begin
		int unsigned waited;
		sb = new;
		arst_n = 1'b0;
		start = 1'b0;
		kind = KIND_TOKEN;
		place = '0;
		color = '0;
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;

		send(KIND_EVAL, '0, pick_gap());
		send(KIND_TOKEN, '1, pick_gap());
		send(KIND_REQ, '1, pick_gap());
		send(KIND_EVAL, '0, pick_gap());
		send(KIND_REQ, '0, pick_gap());
		send(KIND_REQ, '0, pick_gap());
		send(KIND_TOKEN, '0, pick_gap());
		send(KIND_EVAL, '1, pick_gap());
		send(KIND_TOKEN, '0, pick_gap());
		send(KIND_REQ, '0, pick_gap());
		send(KIND_TOKEN, '0, pick_gap());
		send(KIND_REQ, '0, pick_gap());
		send(KIND_EVAL, '0, pick_gap());
		send(KIND_NONE, {10'd5, 8'd5}, pick_gap());
		send(KIND_REQ, {10'd5, 8'd5}, pick_gap());
		send(KIND_EVAL, '0, pick_gap());
		send(KIND_TOKEN, {10'd7, 8'd7}, pick_gap());
		send(KIND_EVAL, '0, pick_gap());
		send(KIND_TOKEN, {10'd3, 8'd4}, pick_gap());
		send(KIND_REQ, {10'd3, 8'd5}, pick_gap());
		send(KIND_EVAL, '0, pick_gap());
		idle_until_drained();

		while (loads_sent + evals_sent < 950 || evals_sent < 60) begin
			run_transition();
		end

		@(negedge clk);
		start <= 1'b0;
		waited = 0;
		while (sb.verdicts_due.size() != 0 && waited < 5000) begin
			@(posedge clk);
			waited++;
		end
		repeat (20) @(posedge clk);

		$display("covered %0d loads, %0d evaluations and %0d ignored items",
			loads_sent, evals_sent, ignored_sent);
		$display("results seen: %0d fireable, %0d with overflow, %0d mismatches",
			sb.fired, sb.flagged, sb.mismatches);
		if (sb.mismatches == 0 && sb.verdicts_due.size() == 0) begin
			$display("testbench OK");
		end else begin
			$display("testbench NOT OK");
		end
		$finish;
	end

endmodule
